### sv/gcfs_pkg.sv
package gcfs_pkg;

    // Default table depth.
    localparam int TABLE_ENTRIES_DEF = 256;

    // Fixed field widths.
    localparam int GRAN_W = 8;
    localparam int TAIL_W = 16;
    localparam int SIZE_W = 20;
    localparam int CNT_W  = 9;
    localparam int STAT_W = 2;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Table entry codes and byte counts.
    localparam logic [GRAN_W-1:0] LINK_LIMIT    = 8'hC0;
    localparam logic [GRAN_W-1:0] TERM_BASE     = 8'hC1;
    localparam logic [SIZE_W-1:0] GRANULE_BYTES = 20'd2304;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_LONG     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_TERM = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic write;
        logic start_read;
        logic step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query;
        logic start_ok;
        logic walk_done;
        logic out_free;
    } t_dp_stat;

endpackage

### sv/gcfs_ctrl.sv
module gcfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gcfs_pkg::t_dp_stat i_stat,
    output gcfs_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);

    gcfs_pkg::t_state r_state;
    gcfs_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcfs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcfs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.query && i_stat.start_ok) begin
                        n_state = gcfs_pkg::S_WALK;
                    end else begin
                        n_state = gcfs_pkg::S_DONE;
                    end
                end
            end
            gcfs_pkg::S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = gcfs_pkg::S_DONE;
                end
            end
            gcfs_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = gcfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gcfs_pkg::S_IDLE;
            end
        endcase
    end

    // Commands and input stall.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            gcfs_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept     = 1'b1;
                    o_cmd.write      = !i_stat.query;
                    o_cmd.start_read = i_stat.query && i_stat.start_ok;
                end
            end
            gcfs_pkg::S_WALK: begin
                o_cmd.step = 1'b1;
            end
            gcfs_pkg::S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

### sv/gcfs_dp.sv
module gcfs_dp #(
    parameter int TABLE_ENTRIES = gcfs_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gcfs_pkg::t_dp_cmd           i_cmd,
    output gcfs_pkg::t_dp_stat          o_stat,
    input  logic                        i_opcode,
    input  logic [gcfs_pkg::GRAN_W-1:0] i_entry_index,
    input  logic [gcfs_pkg::GRAN_W-1:0] i_entry_value,
    input  logic [gcfs_pkg::GRAN_W-1:0] i_start_granule,
    input  logic [gcfs_pkg::TAIL_W-1:0] i_last_bytes,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [gcfs_pkg::SIZE_W-1:0] o_byte_total,
    output logic [gcfs_pkg::CNT_W-1:0]  o_granule_count,
    output logic [gcfs_pkg::STAT_W-1:0] o_status
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [gcfs_pkg::CNT_W-1:0] DEPTH = gcfs_pkg::CNT_W'(TABLE_ENTRIES);

    // Allocation table.
    logic [gcfs_pkg::GRAN_W-1:0] r_mem [0:TABLE_ENTRIES-1];
    logic [gcfs_pkg::GRAN_W-1:0] r_rdata;
    logic [IDX_W-1:0]            rd_addr;

    logic [gcfs_pkg::TAIL_W-1:0] r_tail;
    logic [gcfs_pkg::SIZE_W-1:0] r_size;
    logic [gcfs_pkg::CNT_W-1:0]  r_count;
    logic [gcfs_pkg::STAT_W-1:0] r_res_status;

    logic [gcfs_pkg::CNT_W-1:0]  count_n;
    logic [gcfs_pkg::SIZE_W-1:0] term_size;
    logic                        is_link;
    logic                        is_bad_term;
    logic                        link_off;
    logic                        too_long;
    logic                        idx_ok;
    logic                        out_free;

    // Decode of the entry read in this step.
    assign count_n     = r_count + gcfs_pkg::CNT_W'(1);
    assign is_link     = r_rdata < gcfs_pkg::LINK_LIMIT;
    assign is_bad_term = r_rdata == gcfs_pkg::LINK_LIMIT;
    assign link_off    = {1'b0, r_rdata} >= DEPTH;
    assign too_long    = count_n == DEPTH;
    assign term_size   = r_size
                       + {4'b0, r_rdata - gcfs_pkg::TERM_BASE, 8'h00}
                       + {4'b0, r_tail};

    assign idx_ok   = {1'b0, i_entry_index} < DEPTH;
    assign out_free = !o_out_valid || !i_out_stall;

    assign o_stat.query     = i_opcode == gcfs_pkg::OP_QUERY;
    assign o_stat.start_ok  = {1'b0, i_start_granule} < DEPTH;
    assign o_stat.walk_done = !is_link || link_off || too_long;
    assign o_stat.out_free  = out_free;

    // Read address: the start granule first, then the link just read.
    assign rd_addr = i_cmd.step ? r_rdata[IDX_W-1:0] : i_start_granule[IDX_W-1:0];

    // Table write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && idx_ok) begin
            r_mem[i_entry_index[IDX_W-1:0]] <= i_entry_value;
        end
        if (i_cmd.start_read || i_cmd.step) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Walk accumulators and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tail  <= i_last_bytes;
            r_size  <= '0;
            r_count <= '0;
            if (o_stat.query && !o_stat.start_ok) begin
                r_res_status <= gcfs_pkg::ST_LONG;
            end else begin
                r_res_status <= gcfs_pkg::ST_OK;
            end
        end else if (i_cmd.step) begin
            r_count <= count_n;
            if (is_link) begin
                if (link_off || too_long) begin
                    r_size       <= '0;
                    r_res_status <= gcfs_pkg::ST_LONG;
                end else begin
                    r_size <= r_size + gcfs_pkg::GRANULE_BYTES;
                end
            end else if (is_bad_term) begin
                r_size       <= '0;
                r_res_status <= gcfs_pkg::ST_BAD_TERM;
            end else begin
                r_size       <= term_size;
                r_res_status <= gcfs_pkg::ST_OK;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_byte_total    <= r_size;
            o_granule_count <= r_count;
            o_status        <= r_res_status;
        end
    end

endmodule

### sv/granule_chain_file_size.sv
// Granule chain file size.
// The host first loads the allocation table with write words (opcode 0),
// one entry each; every write answers with a zero result word. A query word
// (opcode 1) gives a start granule and the byte count of the last sector; the
// block follows the chain and answers with the file size, the number of
// granules visited and a status (ok, chain too long or off the table, bad
// terminal entry). Both channels use valid and stall; every input word gives
// exactly one output word, in order.
// A write goes from idle straight to the done state, where its result word is
// loaded into the output register once that is free. A query whose start
// granule is on the table first walks the chain over the N granules visited
// (at most TABLE_ENTRIES), reading one table entry per cycle through the single
// read port of the table. One word is worked on at a time and the input is
// stalled until its result is loaded.
// A finished word waits in the output register while the block takes the
// next input word; when the next result is ready while the first is still
// held by a stalling receiver, the block keeps it and keeps the input stalled.
// Reset clears the controller and the output valid; the table contents are
// undefined until written, and reading an unwritten entry gives no guarantee.
module granule_chain_file_size #(
    parameter int TABLE_ENTRIES = gcfs_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [gcfs_pkg::GRAN_W-1:0] i_entry_index,
    input  logic [gcfs_pkg::GRAN_W-1:0] i_entry_value,
    input  logic [gcfs_pkg::GRAN_W-1:0] i_start_granule,
    input  logic [gcfs_pkg::TAIL_W-1:0] i_last_bytes,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gcfs_pkg::SIZE_W-1:0] o_byte_total,
    output logic [gcfs_pkg::CNT_W-1:0]  o_granule_count,
    output logic [gcfs_pkg::STAT_W-1:0] o_status
);

    gcfs_pkg::t_dp_cmd  cmd;
    gcfs_pkg::t_dp_stat stat;

    // Sequencer.
    gcfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Table, walk accumulators and output register.
    gcfs_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_start_granule (i_start_granule),
        .i_last_bytes    (i_last_bytes),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_byte_total    (o_byte_total),
        .o_granule_count (o_granule_count),
        .o_status        (o_status)
    );

endmodule

### tb/granule_chain_file_size_tb.sv
// Tracks the allocation table as the block should see it and keeps the result
// words still due, oldest first.
class chain_board;
    typedef struct packed {
        logic [gcfs_pkg::SIZE_W-1:0] byte_total;
        logic [gcfs_pkg::CNT_W-1:0]  granule_count;
        logic [gcfs_pkg::STAT_W-1:0] status;
    } t_size_word;

    localparam int TABLE_DEPTH  = gcfs_pkg::TABLE_ENTRIES_DEF;
    localparam int SECTOR_BYTES = 256;

    logic [gcfs_pkg::GRAN_W-1:0] granule_map [TABLE_DEPTH];
    bit                          loaded      [TABLE_DEPTH];
    t_size_word                  sizes_due[$];
    int                          errors;

    function new();
        errors = 0;
        foreach (loaded[i]) begin
            loaded[i] = 1'b0;
            granule_map[i] = '0;
        end
    endfunction

    // Follows the chain from start and sums its bytes. The blind flag is set
    // when the walk touches an entry that has never been loaded.
    function t_size_word walk_chain_size(input logic [gcfs_pkg::GRAN_W-1:0] start,
                                         input logic [gcfs_pkg::TAIL_W-1:0] tail,
                                         output bit blind);
        t_size_word                  res;
        int unsigned                 g;
        int unsigned                 visits;
        int unsigned                 bytes;
        logic [gcfs_pkg::GRAN_W-1:0] e;
        res = '0;
        blind = 1'b0;
        g = start;
        visits = 0;
        bytes = 0;
        if (g >= TABLE_DEPTH) begin
            res.status = gcfs_pkg::ST_LONG;
            return res;
        end
        while (visits < TABLE_DEPTH) begin
            if (!loaded[g]) begin
                blind = 1'b1;
            end
            e = granule_map[g];
            visits++;
            res.granule_count = visits[gcfs_pkg::CNT_W-1:0];
            if (e < gcfs_pkg::LINK_LIMIT) begin
                bytes += gcfs_pkg::GRANULE_BYTES;
                g = e;
                if (g >= TABLE_DEPTH) begin
                    res.status = gcfs_pkg::ST_LONG;
                    return res;
                end
            end else if (e == gcfs_pkg::LINK_LIMIT) begin
                res.status = gcfs_pkg::ST_BAD_TERM;
                return res;
            end else begin
                bytes += (int'(e) - int'(gcfs_pkg::TERM_BASE)) * SECTOR_BYTES + int'(tail);
                res.byte_total = bytes[gcfs_pkg::SIZE_W-1:0];
                res.status = gcfs_pkg::ST_OK;
                return res;
            end
        end
        // Ran the whole table length without a terminal entry.
        res.status = gcfs_pkg::ST_LONG;
        return res;
    endfunction

    // True when every entry along the chain from start has been loaded.
    function bit chain_loaded(input logic [gcfs_pkg::GRAN_W-1:0] start);
        bit         blind;
        t_size_word res;
        res = walk_chain_size(start, '0, blind);
        return !blind;
    endfunction

    // Notes an accepted input word: a write updates the table, and every word
    // owes exactly one result word.
    function void note_word(input logic op,
                            input logic [gcfs_pkg::GRAN_W-1:0] idx,
                            input logic [gcfs_pkg::GRAN_W-1:0] val,
                            input logic [gcfs_pkg::GRAN_W-1:0] start,
                            input logic [gcfs_pkg::TAIL_W-1:0] tail);
        bit blind;
        if (op == gcfs_pkg::OP_WRITE) begin
            if (idx < TABLE_DEPTH) begin
                granule_map[idx] = val;
                loaded[idx] = 1'b1;
            end
            sizes_due.push_back('0);
        end else begin
            sizes_due.push_back(walk_chain_size(start, tail, blind));
        end
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Compares one accepted result word with the oldest one due.
    task check_word(input logic [gcfs_pkg::SIZE_W-1:0] size,
                    input logic [gcfs_pkg::CNT_W-1:0]  count,
                    input logic [gcfs_pkg::STAT_W-1:0] status);
        t_size_word want;
        if (sizes_due.size() == 0) begin
            report($sformatf("result word with nothing due (size %0d count %0d status %0d)",
                             size, count, status));
            return;
        end
        want = sizes_due.pop_front();
        if (size !== want.byte_total) begin
            report($sformatf("byte total expected %0d, got %0d", want.byte_total, size));
        end
        if (count !== want.granule_count) begin
            report($sformatf("granule_count expected %0d, got %0d", want.granule_count, count));
        end
        if (status !== want.status) begin
            report($sformatf("status expected %0d, got %0d", want.status, status));
        end
    endtask
endclass

module granule_chain_file_size_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int TABLE_DEPTH  = gcfs_pkg::TABLE_ENTRIES_DEF;
    localparam int LINK_SPAN    = int'(gcfs_pkg::LINK_LIMIT);
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 300;
    localparam int PHASE_WORDS  = 40;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        o_in_stall;
    logic                        opcode = gcfs_pkg::OP_WRITE;
    logic [gcfs_pkg::GRAN_W-1:0] entry_index = '0;
    logic [gcfs_pkg::GRAN_W-1:0] entry_value = '0;
    logic [gcfs_pkg::GRAN_W-1:0] start_granule = '0;
    logic [gcfs_pkg::TAIL_W-1:0] last_bytes = '0;
    logic                        o_out_valid;
    logic                        out_stall = 1'b0;
    logic [gcfs_pkg::SIZE_W-1:0] o_byte_total;
    logic [gcfs_pkg::CNT_W-1:0]  o_granule_count;
    logic [gcfs_pkg::STAT_W-1:0] o_status;

    chain_board                  board;
    int                          send_idle_pct = 0;
    int                          stall_pct = 0;
    bit                          hold_req = 1'b0;
    int                          words_sent = 0;
    logic [gcfs_pkg::GRAN_W-1:0] pick [LINK_SPAN];

    granule_chain_file_size #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (opcode),
        .i_entry_index  (entry_index),
        .i_entry_value  (entry_value),
        .i_start_granule(start_granule),
        .i_last_bytes   (last_bytes),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_byte_total   (o_byte_total),
        .o_granule_count(o_granule_count),
        .o_status       (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offers one word after a random gap and waits until the block takes it.
    task automatic send_word(input logic op, input logic [gcfs_pkg::GRAN_W-1:0] idx,
                             input logic [gcfs_pkg::GRAN_W-1:0] val,
                             input logic [gcfs_pkg::GRAN_W-1:0] start,
                             input logic [gcfs_pkg::TAIL_W-1:0] tail);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        entry_value <= val;
        start_granule <= start;
        last_bytes <= tail;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.note_word(op, idx, val, start, tail);
        words_sent++;
    endtask

    // Fields that a word does not use carry random values.
    task automatic write_entry(input logic [gcfs_pkg::GRAN_W-1:0] idx,
                               input logic [gcfs_pkg::GRAN_W-1:0] val);
        send_word(gcfs_pkg::OP_WRITE, idx, val, gcfs_pkg::GRAN_W'($urandom),
                  gcfs_pkg::TAIL_W'($urandom));
    endtask

    task automatic query_chain(input logic [gcfs_pkg::GRAN_W-1:0] start,
                               input logic [gcfs_pkg::TAIL_W-1:0] tail);
        send_word(gcfs_pkg::OP_QUERY, gcfs_pkg::GRAN_W'($urandom),
                  gcfs_pkg::GRAN_W'($urandom), start, tail);
    endtask

    function automatic logic [gcfs_pkg::TAIL_W-1:0] pick_tail();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return gcfs_pkg::TAIL_W'($urandom);
        endcase
    endfunction

    // Mostly a proper terminal entry, now and then the bad one.
    function automatic logic [gcfs_pkg::GRAN_W-1:0] pick_terminal();
        if ($urandom_range(9) == 0) begin
            return gcfs_pkg::LINK_LIMIT;
        end
        return gcfs_pkg::GRAN_W'($urandom_range(int'(gcfs_pkg::TERM_BASE), 255));
    endfunction

    // Lays down a file of distinct linkable granules, optionally headed by a
    // granule that no link can name, ends it or closes it into a loop, then
    // asks for its size.
    task automatic build_file(input int links, input bit cyclic, input bit high_head);
        int                          i;
        int                          j;
        logic [gcfs_pkg::GRAN_W-1:0] t;
        logic [gcfs_pkg::GRAN_W-1:0] head;
        for (i = 0; i < links; i++) begin
            j = $urandom_range(i, LINK_SPAN - 1);
            t = pick[i];
            pick[i] = pick[j];
            pick[j] = t;
        end
        head = high_head ? gcfs_pkg::GRAN_W'($urandom_range(LINK_SPAN, TABLE_DEPTH - 1))
                         : pick[0];
        if (high_head) begin
            write_entry(head, pick[0]);
        end
        for (i = 0; i + 1 < links; i++) begin
            write_entry(pick[i], pick[i + 1]);
        end
        write_entry(pick[links - 1], cyclic ? pick[0] : pick_terminal());
        query_chain(head, pick_tail());
    endtask

    // Sender pause: drop valid and wait until every result word is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.sizes_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One traffic phase: mostly complete files with random content, plus
    // queries on loaded chains and stray writes.
    task automatic run_phase(input int sender_pct, input int receiver_pct, input int count);
        int                          goal;
        int                          r;
        int                          links;
        logic [gcfs_pkg::GRAN_W-1:0] s;
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
        goal = words_sent + count;
        while (words_sent < goal) begin
            r = $urandom_range(99);
            if (r < 60) begin
                links = ($urandom_range(3) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
                build_file(links, $urandom_range(9) == 0, $urandom_range(3) == 0);
            end else if (r < 80) begin
                s = gcfs_pkg::GRAN_W'($urandom);
                if (board.chain_loaded(s)) begin
                    query_chain(s, pick_tail());
                end else begin
                    write_entry(s, gcfs_pkg::GRAN_W'($urandom));
                end
            end else begin
                write_entry(gcfs_pkg::GRAN_W'($urandom), gcfs_pkg::GRAN_W'($urandom));
            end
        end
        drain_results();
    endtask

    // Receiver: checks each accepted result word and drives the stall for the
    // next cycle, including the long hold-off when one is requested.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
                board.check_word(o_byte_total, o_granule_count, o_status);
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("granule_chain_file_size_tb: errors");
        $finish;
    end

    initial begin : stimulus
        board = new();
        foreach (pick[i]) begin
            pick[i] = gcfs_pkg::GRAN_W'(i);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest and largest terminal, the bad terminal, a short
        // chain, loops of one and two granules, a link into a bad terminal and
        // a link naming granule zero.
        write_entry(8'h00, gcfs_pkg::TERM_BASE);
        query_chain(8'h00, '0);
        write_entry(8'hFF, 8'hFF);
        query_chain(8'hFF, '1);
        write_entry(8'h10, gcfs_pkg::LINK_LIMIT);
        query_chain(8'h10, 16'h1234);
        write_entry(8'h20, 8'h21);
        write_entry(8'h21, 8'hBF);
        write_entry(8'hBF, 8'hC5);
        query_chain(8'h20, 16'd100);
        write_entry(8'h30, 8'h30);
        query_chain(8'h30, '1);
        write_entry(8'h40, 8'h41);
        write_entry(8'h41, 8'h40);
        query_chain(8'h40, '0);
        write_entry(8'h50, 8'h10);
        query_chain(8'h50, 16'h8000);
        write_entry(8'h60, 8'h00);
        query_chain(8'h60, 16'h7FFF);
        drain_results();

        // No idling at all.
        run_phase(0, 0, PHASE_WORDS);

        // Longest chain that can end properly, with the sender idling.
        send_idle_pct = 45;
        build_file(LINK_SPAN, 1'b0, 1'b1);
        run_phase(45, 0, PHASE_WORDS);

        // Receiver holds off for a long stretch while words keep coming.
        hold_req = 1'b1;
        run_phase(0, 45, PHASE_WORDS);

        // A long loop, then light idling on both sides.
        stall_pct = 7;
        send_idle_pct = 7;
        build_file(30, 1'b1, 1'b0);
        run_phase(7, 7, PHASE_WORDS);

        run_phase(0, 0, PHASE_WORDS / 2);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.sizes_due.size() == 0) begin
            $display("granule_chain_file_size_tb: clean");
        end else begin
            $display("granule_chain_file_size_tb: errors");
        end
        $finish;
    end
endmodule

### files.f
sv/gcfs_pkg.sv
sv/gcfs_ctrl.sv
sv/gcfs_dp.sv
sv/granule_chain_file_size.sv
tb/granule_chain_file_size_tb.sv
